// File: sv/ndbf_pkg.sv
// Shared constants, codes and types of the box fill address generator.
package ndbf_pkg;

	localparam int MAX_DIMS   = 3;
	localparam int DIM_BITS   = 10;
	localparam int DATA_WIDTH = 32;
	localparam int EXT_W      = DIM_BITS + 1;
	localparam int SIZE_W     = 11;
	localparam int COORD_W    = 11;
	localparam int SUM_W      = 12;
	localparam int ADDR_W     = 30;
	localparam int NDIM_W     = 2;
	localparam int REG_IDX_W  = 2;
	localparam int PART_W     = 2 * COORD_W + 1;
	localparam int PROD_W     = PART_W + SIZE_W;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_0 = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_1 = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_2 = 2'd3;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_ZERO   = 2'd2
	} status_t;

	typedef struct packed {
		logic                                 command;
		logic [DATA_WIDTH-1:0]                fill_value;
		logic [MAX_DIMS-1:0][DIM_BITS-1:0]    start;
		logic [MAX_DIMS-1:0][EXT_W-1:0]       extent;
	} req_t;

	typedef struct packed {
		logic [NDIM_W-1:0]                    num_dims;
		logic [MAX_DIMS-1:0][SIZE_W-1:0]      dim_size;
	} cfg_t;

	typedef struct packed {
		logic [MAX_DIMS-1:0][COORD_W-1:0]     coord;
		logic [DATA_WIDTH-1:0]                value;
		logic                                 last;
		status_t                              status;
	} step_t;

endpackage

// File: sv/ndbf_if.sv
// Channel interfaces: box requests in, write words out.
interface ndbf_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] fill_value;
	logic [9:0]  start_0;
	logic [9:0]  start_1;
	logic [9:0]  start_2;
	logic [10:0] extent_0;
	logic [10:0] extent_1;
	logic [10:0] extent_2;

	modport source (output valid, command, fill_value, start_0, start_1, start_2,
		extent_0, extent_1, extent_2, input ready);
	modport sink (input valid, command, fill_value, start_0, start_1, start_2,
		extent_0, extent_1, extent_2, output ready);
endinterface

interface ndbf_wr_if;
	logic        valid;
	logic        ready;
	logic [29:0] write_address;
	logic [31:0] write_value;
	logic        last;
	logic [1:0]  status;

	modport source (output valid, write_address, write_value, last, status, input ready);
	modport sink (input valid, write_address, write_value, last, status, output ready);
endinterface

// File: sv/ndbf_walker.sv
// Box walk state: request checking, coordinate odometer and end detection.
module ndbf_walker import ndbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  req_t  req,
	input  cfg_t  cfg,
	output logic  step_valid,
	output step_t step
);

	logic [NDIM_W-1:0]                 dims_q;
	logic                              busy_q;
	logic [MAX_DIMS-1:0][COORD_W-1:0]  coord_q;
	logic [MAX_DIMS-1:0][DIM_BITS-1:0] start_q;
	logic [MAX_DIMS-1:0][COORD_W-1:0]  end_q;
	logic [DATA_WIDTH-1:0]             held_q;

	logic [NDIM_W-1:0]                 dims;
	logic [MAX_DIMS-1:0][COORD_W-1:0]  coord_nx;
	logic [MAX_DIMS-1:0][DIM_BITS-1:0] start_nx;
	logic [MAX_DIMS-1:0][COORD_W-1:0]  end_nx;
	logic [MAX_DIMS-1:0][SUM_W-1:0]    sum;
	logic [DATA_WIDTH-1:0]             value_nx;
	status_t                           err;
	logic                              carry;
	logic                              at_end;
	logic [COORD_W-1:0]                inc;
	logic                              is_req;

	assign is_req = (req.command == CMD_REQUEST);

	always_comb begin
		dims     = is_req ? cfg.num_dims : dims_q;
		start_nx = start_q;
		end_nx   = end_q;
		coord_nx = coord_q;
		value_nx = held_q;
		err      = ST_OK;
		carry    = 1'b1;
		inc      = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			sum[d] = SUM_W'(req.start[d]) + SUM_W'(req.extent[d]);
		end
		if (is_req) begin
			start_nx = req.start;
			value_nx = req.fill_value;
			for (int d = 0; d < MAX_DIMS; d++) begin
				end_nx[d]   = sum[d][COORD_W-1:0];
				coord_nx[d] = COORD_W'(req.start[d]);
				// Higher dimensions come later in the loop, so their failure wins.
				if (NDIM_W'(d) < dims) begin
					if (sum[d] > SUM_W'(cfg.dim_size[d])) begin
						err = ST_BOUNDS;
					end else if (req.extent[d] == '0) begin
						err = ST_ZERO;
					end
				end
			end
		end else begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				if (NDIM_W'(d) < dims && carry) begin
					inc = coord_q[d] + COORD_W'(1);
					if (inc == end_q[d]) begin
						coord_nx[d] = COORD_W'(start_q[d]);
					end else begin
						coord_nx[d] = inc;
						carry       = 1'b0;
					end
				end
			end
		end
		at_end = 1'b1;
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (NDIM_W'(d) < dims &&
				(SUM_W'(coord_nx[d]) + SUM_W'(1)) != SUM_W'(end_nx[d])) begin
				at_end = 1'b0;
			end
		end
	end

	always_comb begin
		step_valid = accept && (is_req || busy_q);
		for (int d = 0; d < MAX_DIMS; d++) begin
			step.coord[d] = (NDIM_W'(d) < dims && err == ST_OK) ? coord_nx[d] : '0;
		end
		step.value  = (err == ST_OK) ? value_nx : '0;
		step.last   = (err != ST_OK) || at_end;
		step.status = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= '0;
			busy_q <= 1'b0;
		end else if (accept && (is_req || busy_q)) begin
			dims_q <= dims;
			busy_q <= (err == ST_OK) && !at_end;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (is_req || busy_q)) begin
			coord_q <= coord_nx;
			start_q <= start_nx;
			end_q   <= end_nx;
			held_q  <= value_nx;
		end
	end

endmodule

// File: sv/ndbf_addr_pipe.sv
// Three-stage linear address pipeline with stall handling and output register.
module ndbf_addr_pipe import ndbf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         step_valid,
	input  step_t        step,
	output logic         step_ready,
	ndbf_wr_if.source    wr
);

	logic                  valid_s1;
	step_t                 step_s1;
	logic                  valid_s2;
	logic [PART_W-1:0]     part_s2;
	logic [COORD_W-1:0]    c0_s2;
	logic [DATA_WIDTH-1:0] value_s2;
	logic                  last_s2;
	status_t               status_s2;
	logic                  valid_s3;
	logic [ADDR_W-1:0]     addr_s3;
	logic [DATA_WIDTH-1:0] value_s3;
	logic                  last_s3;
	status_t               status_s3;

	logic                  free_s1;
	logic                  free_s2;
	logic                  free_s3;
	logic [PART_W-1:0]     part;
	logic [PROD_W:0]       full_addr;

	assign free_s3    = !valid_s3 || wr.ready;
	assign free_s2    = !valid_s2 || free_s3;
	assign free_s1    = !valid_s1 || free_s2;
	assign step_ready = free_s1;

	// Address in Horner form: c0 + size0 * (c1 + size1 * c2).
	assign part = PART_W'(step_s1.coord[2]) * PART_W'(cfg.dim_size[1])
		+ PART_W'(step_s1.coord[1]);
	assign full_addr = (PROD_W+1)'(part_s2) * (PROD_W+1)'(cfg.dim_size[0])
		+ (PROD_W+1)'(c0_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= step_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1) begin
			step_s1 <= step;
		end
		if (free_s2) begin
			part_s2   <= part;
			c0_s2     <= step_s1.coord[0];
			value_s2  <= step_s1.value;
			last_s2   <= step_s1.last;
			status_s2 <= step_s1.status;
		end
		if (free_s3) begin
			addr_s3   <= full_addr[ADDR_W-1:0];
			value_s3  <= value_s2;
			last_s3   <= last_s2;
			status_s3 <= status_s2;
		end
	end

	assign wr.valid         = valid_s3;
	assign wr.write_address = addr_s3;
	assign wr.write_value   = value_s3;
	assign wr.last          = last_s3;
	assign wr.status        = status_s3;

endmodule

// File: sv/nd_box_fill_address_generator.sv
// Top level of the N-dimensional box fill address generator.
//
//   channel   direction   word                                 handshake
//   req       in          command, fill value, starts, extents valid/ready
//   wr        out         write address, value, last, status   valid/ready
//   cfg       in          register index and data              cfg_we only
//
// One word is accepted per cycle while req.ready is high; its write word passes through the
// step register, the partial product register and the output register of the address pipe
// before it is valid on wr.
// A tick while no box is open is accepted and gives no word.
// When wr stalls, the pipe fills and req.ready drops once all three stages hold words.
// Reset clears the pipe, the walk and the registers to one dimension of size one.
module nd_box_fill_address_generator import ndbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	ndbf_req_if.sink             req,
	ndbf_wr_if.source            wr,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_wdata
);

	cfg_t  cfg_q;
	req_t  req_word;
	logic  accept;
	logic  step_valid;
	logic  step_ready;
	step_t step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_dims <= NDIM_W'(1);
			for (int d = 0; d < MAX_DIMS; d++) begin
				cfg_q.dim_size[d] <= SIZE_W'(1);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_DIMS:   cfg_q.num_dims    <= cfg_wdata[NDIM_W-1:0];
				REG_DIM_SIZE_0: cfg_q.dim_size[0] <= cfg_wdata;
				REG_DIM_SIZE_1: cfg_q.dim_size[1] <= cfg_wdata;
				REG_DIM_SIZE_2: cfg_q.dim_size[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign req_word.command    = req.command;
	assign req_word.fill_value = req.fill_value;
	assign req_word.start[0]   = req.start_0;
	assign req_word.start[1]   = req.start_1;
	assign req_word.start[2]   = req.start_2;
	assign req_word.extent[0]  = req.extent_0;
	assign req_word.extent[1]  = req.extent_1;
	assign req_word.extent[2]  = req.extent_2;

	assign req.ready = step_ready;
	assign accept    = req.valid && step_ready;

	ndbf_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req        (req_word),
		.cfg        (cfg_q),
		.step_valid (step_valid),
		.step       (step)
	);

	ndbf_addr_pipe u_addr_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step_valid (step_valid),
		.step       (step),
		.step_ready (step_ready),
		.wr         (wr)
	);

endmodule
